@@ sv/ntc_pkg.sv @@
// ----------------------------------------------------------------------------
// NTC conversion package
// Shared constants and the thermistor curve for the ADC-to-temperature block.
// ----------------------------------------------------------------------------
package ntc_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int TEMP_W       = 12;
	localparam int CAL_W        = 11;
	localparam int TAB_W        = 12;
	localparam int IDX_W        = 8;
	localparam int NUM_W        = 16;
	localparam int SUM_W        = 14;
	localparam int CURVE_STORED = 191;

	localparam int TEMP_INDEX_BIAS = 39;
	localparam int TEMP_DELTA      = 15;
	localparam int TEMP_MAX        = 1400;
	localparam int TEMP_MIN        = -280;

	// Divider voltage (inverted reading) per one-degree step, rising.
	localparam logic [TAB_W-1:0] NTC_CURVE [CURVE_STORED] = '{
		12'd193,  12'd204,  12'd215,  12'd227,  12'd239,  12'd252,  12'd265,  12'd279,
		12'd294,  12'd309,  12'd324,  12'd340,  12'd357,  12'd375,  12'd393,  12'd411,
		12'd431,  12'd451,  12'd471,  12'd492,  12'd514,  12'd537,  12'd560,  12'd584,
		12'd609,  12'd635,  12'd661,  12'd687,  12'd715,  12'd743,  12'd772,  12'd801,
		12'd831,  12'd862,  12'd893,  12'd925,  12'd957,  12'd991,  12'd1024, 12'd1058,
		12'd1093, 12'd1128, 12'd1164, 12'd1200, 12'd1236, 12'd1273, 12'd1310, 12'd1348,
		12'd1386, 12'd1424, 12'd1463, 12'd1501, 12'd1540, 12'd1579, 12'd1618, 12'd1657,
		12'd1697, 12'd1736, 12'd1775, 12'd1815, 12'd1854, 12'd1893, 12'd1932, 12'd1971,
		12'd2010, 12'd2048, 12'd2087, 12'd2125, 12'd2163, 12'd2200, 12'd2238, 12'd2274,
		12'd2311, 12'd2347, 12'd2383, 12'd2418, 12'd2453, 12'd2488, 12'd2522, 12'd2556,
		12'd2589, 12'd2622, 12'd2654, 12'd2685, 12'd2717, 12'd2747, 12'd2777, 12'd2807,
		12'd2836, 12'd2865, 12'd2893, 12'd2921, 12'd2948, 12'd2974, 12'd3000, 12'd3026,
		12'd3051, 12'd3075, 12'd3099, 12'd3123, 12'd3146, 12'd3168, 12'd3190, 12'd3212,
		12'd3233, 12'd3253, 12'd3273, 12'd3293, 12'd3312, 12'd3331, 12'd3349, 12'd3367,
		12'd3384, 12'd3401, 12'd3418, 12'd3434, 12'd3450, 12'd3465, 12'd3481, 12'd3495,
		12'd3510, 12'd3524, 12'd3537, 12'd3551, 12'd3564, 12'd3576, 12'd3588, 12'd3600,
		12'd3612, 12'd3624, 12'd3635, 12'd3646, 12'd3656, 12'd3667, 12'd3677, 12'd3686,
		12'd3696, 12'd3705, 12'd3714, 12'd3723, 12'd3732, 12'd3740, 12'd3748, 12'd3756,
		12'd3764, 12'd3772, 12'd3779, 12'd3786, 12'd3793, 12'd3800, 12'd3807, 12'd3813,
		12'd3820, 12'd3826, 12'd3832, 12'd3838, 12'd3844, 12'd3849, 12'd3855, 12'd3860,
		12'd3865, 12'd3870, 12'd3875, 12'd3880, 12'd3884, 12'd3889, 12'd3893, 12'd3898,
		12'd3902, 12'd3906, 12'd3910, 12'd3914, 12'd3918, 12'd3922, 12'd3925, 12'd3929,
		12'd3932, 12'd3936, 12'd3939, 12'd3942, 12'd3945, 12'd3949, 12'd3952, 12'd3954,
		12'd3957, 12'd3960, 12'd3963, 12'd3966, 12'd3968, 12'd3971, 12'd3973
	};

	function automatic logic [TAB_W-1:0] ntc_curve_at(input logic [IDX_W-1:0] idx);
		logic [TAB_W-1:0] val;
		if (int'(idx) < CURVE_STORED) begin
			val = NTC_CURVE[idx];
		end else begin
			val = NTC_CURVE[CURVE_STORED-1];
		end
		return val;
	endfunction

endpackage

@@ sv/ntc_adc_to_temperature_unit.sv @@
// A reading inside the table passes through 7 or 8 search steps, the difference, the
// span, 4 divide steps and the finish; a reading outside it goes straight to the
// finish. The block takes no new sample until it is back in idle; one subtract/compare
// unit is shared by the search, the difference, the span and the divide.
// Reset (arst_n low, asynchronous) returns to idle, drops out_valid and clears the
// calibration offset to zero.
// ----------------------------------------------------------------------------
// NTC ADC sample to temperature converter
// Inverts a 12-bit divider reading, finds its segment of the thermistor curve by
// binary search, interpolates linearly and applies the calibration offset.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_unit
	import ntc_pkg::*;
#(
	parameter int TABLE_ENTRIES  = 191,
	parameter int ADC_FULL_SCALE = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration: calibration offset in tenths of a degree.
	input  logic                      cfg_write_en,
	input  logic signed [CAL_W-1:0]   cfg_write_data,
	// Input channel.
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [SAMPLE_W-1:0]       adc_sample,
	// Result channel.
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [TEMP_W-1:0]  temperature,
	output logic                      abnormal
);

	// The search runs over the stored curve, cut to TABLE_ENTRIES and never
	// shorter than two entries.
	localparam int CURVE_LEN = (TABLE_ENTRIES > CURVE_STORED) ? CURVE_STORED :
		((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
	localparam logic [TAB_W-1:0] CURVE_FIRST = NTC_CURVE[0];
	localparam logic [TAB_W-1:0] CURVE_LAST  = NTC_CURVE[CURVE_LEN-1];

	// The inverted reading can go negative when the sample exceeds full scale,
	// so it is computed one bit wider than either operand.
	localparam int FS_W = $clog2(ADC_FULL_SCALE + 1);
	localparam int V_W  = ((FS_W > SAMPLE_W) ? FS_W : SAMPLE_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIFF,
		ST_SPAN,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                    state_q;
	logic signed [CAL_W-1:0]   cal_q;
	logic [TAB_W-1:0]          v_q;
	logic [IDX_W-1:0]          lo_q;
	logic [IDX_W-1:0]          hi_q;
	logic [TAB_W-1:0]          hi_val_q;
	logic [TAB_W-1:0]          lo_val_q;
	logic [TAB_W-1:0]          span_q;
	logic [NUM_W-1:0]          rem_q;
	logic [3:0]                quot_q;
	logic [1:0]                step_q;
	logic                      bad_q;
	logic                      out_valid_q;
	logic signed [TEMP_W-1:0]  temperature_q;
	logic                      abnormal_q;

	logic                      in_xfer;
	logic signed [V_W-1:0]     v_full;
	logic                      below_table;
	logic                      above_table;
	logic [IDX_W-1:0]          mid;
	logic [IDX_W-1:0]          tab_addr;
	logic [TAB_W-1:0]          tab_rd;
	logic [NUM_W-1:0]          alu_a;
	logic [NUM_W-1:0]          alu_b;
	logic [NUM_W:0]            alu_diff;
	logic                      alu_ge;
	logic [NUM_W-1:0]          num_x10;
	logic [IDX_W-1:0]          next_gap;
	logic [3:0]                frac;
	logic signed [SUM_W-1:0]   idx_off;
	logic signed [SUM_W-1:0]   idx_x10;
	logic signed [SUM_W-1:0]   temp_sum;
	logic                      out_of_range;
	logic                      result_bad;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_xfer     = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign temperature = temperature_q;
	assign abnormal    = abnormal_q;

	// Range checks on the inverted reading are done once, at the input transfer.
	assign v_full      = $signed(V_W'(ADC_FULL_SCALE)) - $signed(V_W'(adc_sample));
	assign below_table = v_full < $signed(V_W'(CURVE_FIRST));
	assign above_table = v_full > $signed(V_W'(CURVE_LAST));

	// The invariant of the search is that the answer lies in (lo, hi] and that
	// the curve at hi is not below the reading. A single read port serves both
	// the probe at the midpoint and the lower segment end.
	assign mid      = IDX_W'((({1'b0, lo_q}) + ({1'b0, hi_q})) >> 1);
	assign tab_addr = (state_q == ST_DIFF) ? (hi_q - IDX_W'(1)) : mid;
	assign tab_rd   = ntc_curve_at(tab_addr);

	// The shared unit: one subtractor whose borrow doubles as the compare result.
	always_comb begin
		alu_a = rem_q;
		alu_b = NUM_W'(span_q) << step_q;
		case (state_q)
			ST_SEARCH: begin
				alu_a = NUM_W'(tab_rd);
				alu_b = NUM_W'(v_q);
			end
			ST_DIFF: begin
				alu_a = NUM_W'(v_q);
				alu_b = NUM_W'(tab_rd);
			end
			ST_SPAN: begin
				alu_a = NUM_W'(hi_val_q);
				alu_b = NUM_W'(lo_val_q);
			end
			default: begin
				alu_a = rem_q;
				alu_b = NUM_W'(span_q) << step_q;
			end
		endcase
	end

	assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu_ge   = !alu_diff[NUM_W];

	// Ten times the offset inside the segment, by two shifts and an add.
	assign num_x10  = NUM_W'({alu_diff[TAB_W-1:0], 3'b000}) +
		NUM_W'({alu_diff[TAB_W-1:0], 1'b0});

	assign next_gap = alu_ge ? (mid - lo_q) : (hi_q - mid);

	// A flat segment contributes nothing to the interpolation.
	assign frac = (span_q == '0) ? 4'd0 : quot_q;

	// Final sum: ten per table step, the interpolation, the calibration and the
	// fixed offset of the curve.
	assign idx_off  = $signed(SUM_W'(hi_q)) - $signed(SUM_W'(TEMP_INDEX_BIAS));
	assign idx_x10  = (idx_off <<< 3) + (idx_off <<< 1);
	assign temp_sum = idx_x10 + $signed(SUM_W'(frac)) + SUM_W'(cal_q) -
		$signed(SUM_W'(TEMP_DELTA));
	assign out_of_range = (temp_sum > $signed(SUM_W'(TEMP_MAX))) ||
		(temp_sum < $signed(SUM_W'(TEMP_MIN)));
	assign result_bad   = bad_q || out_of_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cal_q         <= '0;
			v_q           <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			hi_val_q      <= '0;
			lo_val_q      <= '0;
			span_q        <= '0;
			rem_q         <= '0;
			quot_q        <= '0;
			step_q        <= '0;
			bad_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			temperature_q <= '0;
			abnormal_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				cal_q <= cfg_write_data;
			end

			// The result register empties on a transfer, unless a new result
			// loads in the same cycle below.
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						v_q      <= v_full[TAB_W-1:0];
						lo_q     <= '0;
						hi_q     <= IDX_W'(CURVE_LEN - 1);
						hi_val_q <= CURVE_LAST;
						bad_q    <= below_table || above_table;
						if (below_table || above_table) begin
							state_q <= ST_FINISH;
						end else if (CURVE_LEN > 2) begin
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_DIFF;
						end
					end
				end
				ST_SEARCH: begin
					if (alu_ge) begin
						hi_q     <= mid;
						hi_val_q <= tab_rd;
					end else begin
						lo_q <= mid;
					end
					if (next_gap <= IDX_W'(1)) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					rem_q    <= num_x10;
					lo_val_q <= tab_rd;
					state_q  <= ST_SPAN;
				end
				ST_SPAN: begin
					span_q  <= alu_diff[TAB_W-1:0];
					quot_q  <= '0;
					step_q  <= 2'd3;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// Restoring division, one quotient bit a cycle; the dividend is
					// below sixteen spans, so four bits suffice.
					if (alu_ge) begin
						rem_q <= alu_diff[NUM_W-1:0];
					end
					quot_q <= {quot_q[2:0], alu_ge};
					if (step_q == 2'd0) begin
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q - 2'd1;
					end
				end
				ST_FINISH: begin
					// Wait here while an earlier result is still held back.
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						abnormal_q    <= result_bad;
						temperature_q <= result_bad ? '0 : temp_sum[TEMP_W-1:0];
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/ntc_checker.sv @@
// ----------------------------------------------------------------------------
// NTC converter port checker
// Watches the ports of the converter for result and handshake consistency.
// ----------------------------------------------------------------------------
module ntc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [11:0] temperature,
	input logic               abnormal
);

	// A result held back by the receiver keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(temperature) && $stable(abnormal))
		else $error("result changed while stalled");

	// An abnormal result always reads as zero.
	a_abnormal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && abnormal |-> temperature == 12'sd0)
		else $error("abnormal result with nonzero temperature");

	// A normal result lies inside the reported range.
	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !abnormal |-> temperature <= 12'sd1400 && temperature >= -12'sd280)
		else $error("normal result out of range");

	// The converter is busy in the cycle after it takes a sample.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second sample taken back to back");

endmodule

bind ntc_adc_to_temperature_unit ntc_checker u_ntc_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the NTC ADC-to-temperature converter
// Offers ADC readings under random sender bursts and receiver stalls. Each
// temperature is checked against a typed value from the directed table or a
// table-lookup prediction kept in the bench, over several calibration offsets.
// ----------------------------------------------------------------------------
module tb;
	import ntc_pkg::*;

	// The block is built with its default parameters, so the bench uses the
	// same full scale and table length.
	localparam int ADC_SCALE       = 4096;
	localparam int TABLE_LEN       = 191;
	localparam int SEARCH_LEN      = (TABLE_LEN > CURVE_STORED) ? CURVE_STORED :
	                                 (TABLE_LEN < 2) ? 2 : TABLE_LEN;
	// The pause before a register write and at the end of the run is longer
	// than the longest path through the block.
	localparam int SETTLE_CYCLES   = 24;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_COUNT     = 7;
	localparam int PHASE_ITEMS     = 76;
	localparam int CYCLE_LIMIT     = 300000;

	typedef enum logic {ROW_SAMPLE, ROW_CAL} row_kind_t;

	// One row of the directed table: either a reading to offer or a new
	// calibration offset. Rows marked as typed carry their expected result.
	typedef struct packed {
		row_kind_t                kind;
		logic [SAMPLE_W-1:0]      value;
		logic                     typed;
		logic signed [TEMP_W-1:0] temp;
		logic                     abn;
	} stim_row_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     abn;
	} temp_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_write_en;
	logic signed [CAL_W-1:0]   cfg_write_data;
	logic                      in_valid;
	logic                      in_stall;
	logic [SAMPLE_W-1:0]       adc_sample;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [TEMP_W-1:0]  temperature;
	logic                      abnormal;

	// Calibration offset as the bench believes the block holds it.
	logic signed [CAL_W-1:0]   cal_setting;
	// Temperatures still owed by the block, oldest first.
	temp_result_t              pending_temps[$];
	stim_row_t                 directed_rows[$];
	int unsigned               mismatch_count;
	int unsigned               cycle_count;
	// Set by the stimulus to ask the receiver for one long hold-off.
	bit                        hold_off_req;

	ntc_adc_to_temperature_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.temperature    (temperature),
		.abnormal       (abnormal)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected conversion of one reading. The reading is inverted, the first
	// table entry at index 1 or above that is not below it picks the segment,
	// and the position inside the segment adds 0 to 10 tenths. A reading off
	// either end of the table, or a result outside -28.0 .. 140.0 degrees,
	// gives the abnormal flag and a temperature of zero.
	function automatic temp_result_t convert_reading(input logic [SAMPLE_W-1:0] sample,
	                                                 input logic signed [CAL_W-1:0] cal);
		temp_result_t res;
		int           volts;
		int           seg;
		int           lo;
		int           hi;
		int           frac;
		int           tenths;
		volts     = ADC_SCALE - int'(sample);
		seg       = -1;
		res.temp  = '0;
		res.abn   = 1'b1;
		if (volts >= int'(NTC_CURVE[0])) begin
			for (int i = 1; i < SEARCH_LEN; i++) begin
				if (seg < 0 && int'(NTC_CURVE[i]) >= volts) begin
					seg = i;
				end
			end
		end
		if (seg > 0) begin
			lo     = int'(NTC_CURVE[seg-1]);
			hi     = int'(NTC_CURVE[seg]);
			frac   = (hi > lo) ? ((volts - lo) * 10) / (hi - lo) : 0;
			tenths = (seg - TEMP_INDEX_BIAS) * 10 + frac + int'(cal) - TEMP_DELTA;
			if (tenths <= TEMP_MAX && tenths >= TEMP_MIN) begin
				res.temp = tenths[TEMP_W-1:0];
				res.abn  = 1'b0;
			end
		end
		return res;
	endfunction

	// Most readings land inside the table, some near its two ends, and the
	// rest anywhere in the 12-bit range.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return SAMPLE_W'(ADC_SCALE - int'($urandom_range(int'(NTC_CURVE[0]),
			                                 int'(NTC_CURVE[CURVE_STORED-1]))));
		end else if (pick == 6) begin
			return SAMPLE_W'($urandom_range(0, 160));
		end else if (pick == 7) begin
			return SAMPLE_W'($urandom_range(3860, 4095));
		end else begin
			return SAMPLE_W'($urandom);
		end
	endfunction

	task automatic add_row(input row_kind_t kind, input int value, input bit typed,
	                       input int temp, input bit abn);
		stim_row_t row;
		row.kind  = kind;
		row.value = value[SAMPLE_W-1:0];
		row.typed = typed;
		row.temp  = temp[TEMP_W-1:0];
		row.abn   = abn;
		directed_rows.push_back(row);
	endtask

	// Holds the reading on the input until the block takes it. The expected
	// result is queued at the edge where the transfer happens, using the
	// calibration in force at that moment.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] sample, input bit typed,
	                            input temp_result_t typed_res);
		in_valid   <= 1'b1;
		adc_sample <= sample;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_temps.push_back(typed ? typed_res : convert_reading(sample, cal_setting));
	endtask

	// Lets every owed result come out, then waits out the settle pause so that
	// the block is back in idle.
	task automatic wait_idle();
		while (pending_temps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cal(input logic signed [CAL_W-1:0] value);
		in_valid <= 1'b0;
		wait_idle();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en   <= 1'b0;
		cal_setting     = value;
	endtask

	// Random readings in bursts of 1 to 12 transfers with random gaps between
	// bursts; a gapless phase offers back to back. The caller
	// lowers the valid afterwards.
	task automatic run_phase(input int count, input bit gapless);
		int burst;
		int gap;
		burst = $urandom_range(1, 12);
		for (int k = 0; k < count; k++) begin
			offer_sample(pick_sample(), 1'b0, '0);
			burst--;
			if (!gapless && burst == 0) begin
				gap      = $urandom_range(1, 16);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst = $urandom_range(1, 12);
			end
		end
	endtask

	// Result checker: every transfer on the output is matched against the
	// oldest owed temperature, field by field.
	always @(posedge clk) begin
		temp_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_temps.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual temperature %0d abnormal %0b",
				         $time, temperature, abnormal);
				mismatch_count++;
			end else begin
				want = pending_temps.pop_front();
				if (temperature !== want.temp) begin
					$display("%0t: temperature mismatch, expected %0d, actual %0d",
					         $time, want.temp, temperature);
					mismatch_count++;
				end
				if (abnormal !== want.abn) begin
					$display("%0t: abnormal mismatch, expected %0b, actual %0b",
					         $time, want.abn, abnormal);
					mismatch_count++;
				end
			end
		end
	end

	// Receiver: stalls in segments of random length, each with its own stall
	// rate, from never to mostly. When asked, it holds off for a long stretch
	// so that the block backs up and stalls its input.
	initial begin
		int seg_len;
		int stall_pct;
		out_stall = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				seg_len = $urandom_range(8, 64);
				case ($urandom_range(0, 3))
					0: begin
						stall_pct = 0;
					end
					1: begin
						stall_pct = 20;
					end
					2: begin
						stall_pct = 50;
					end
					default: begin
						stall_pct = 80;
					end
				endcase
				repeat (seg_len) begin
					out_stall <= ($urandom_range(0, 99) < stall_pct);
					@(posedge clk);
				end
			end
		end
	end

	// Watchdog: a run that hangs ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL ntc_adc_to_temperature_unit");
			$finish;
		end
	end

	initial begin
		int        phase_cal[PHASE_COUNT];
		stim_row_t row;

		mismatch_count = 0;
		cycle_count    = 0;
		hold_off_req   = 1'b0;
		cal_setting    = '0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		adc_sample     = '0;
		cfg_write_en   = 1'b0;
		cfg_write_data = '0;

		// Directed table. The calibration is zero after reset.
		// A reading right on a table entry, mid-curve: -1.5 degrees.
		add_row(ROW_SAMPLE, 3072, 1'b1, -15, 1'b0);
		// Reading of zero: inverted value is full scale, above the table.
		add_row(ROW_SAMPLE, 0, 1'b1, 0, 1'b1);
		// Just above the last entry.
		add_row(ROW_SAMPLE, 122, 1'b1, 0, 1'b1);
		// On the last entry: inside the table but far over 140 degrees.
		add_row(ROW_SAMPLE, 123, 1'b1, 0, 1'b1);
		// Full-scale reading: below the table.
		add_row(ROW_SAMPLE, 4095, 1'b1, 0, 1'b1);
		// Just below the first entry.
		add_row(ROW_SAMPLE, 3904, 1'b1, 0, 1'b1);
		// On the first entry: inside the table but under -28 degrees.
		add_row(ROW_SAMPLE, 3903, 1'b1, 0, 1'b1);
		// Either side of the -28.0 degree limit.
		add_row(ROW_SAMPLE, 3748, 1'b0, 0, 1'b0);
		add_row(ROW_SAMPLE, 3747, 1'b0, 0, 1'b0);
		// Either side of the 140.0 degree limit.
		add_row(ROW_SAMPLE, 153, 1'b0, 0, 1'b0);
		add_row(ROW_SAMPLE, 152, 1'b0, 0, 1'b0);
		add_row(ROW_SAMPLE, 2048, 1'b0, 0, 1'b0);
		add_row(ROW_SAMPLE, 12'hAAA, 1'b0, 0, 1'b0);
		add_row(ROW_SAMPLE, 12'h555, 1'b0, 0, 1'b0);
		// Largest positive calibration.
		add_row(ROW_CAL, 1023, 1'b0, 0, 1'b0);
		add_row(ROW_SAMPLE, 3072, 1'b1, 1008, 1'b0);
		add_row(ROW_SAMPLE, 3903, 1'b0, 0, 1'b0);
		add_row(ROW_SAMPLE, 123, 1'b1, 0, 1'b1);
		// Most negative calibration.
		add_row(ROW_CAL, -1024, 1'b0, 0, 1'b0);
		add_row(ROW_SAMPLE, 3072, 1'b1, 0, 1'b1);
		add_row(ROW_SAMPLE, 153, 1'b0, 0, 1'b0);
		add_row(ROW_SAMPLE, 12'hFFF, 1'b1, 0, 1'b1);

		// Calibration for each random phase: the two limits of the register, plus and
		// minus 100.0 degrees, zero, and two random values over the whole register.
		phase_cal[0] = 1023;
		phase_cal[1] = -1024;
		phase_cal[2] = 1000;
		phase_cal[3] = -1000;
		phase_cal[4] = 0;
		phase_cal[5] = int'($urandom_range(0, 2047)) - 1024;
		phase_cal[6] = int'($urandom_range(0, 2047)) - 1024;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < directed_rows.size(); r++) begin
			row = directed_rows[r];
			if (row.kind == ROW_CAL) begin
				write_cal(row.value[CAL_W-1:0]);
			end else begin
				offer_sample(row.value, row.typed, {row.temp, row.abn});
			end
		end

		// Random phases. Every calibration change drains the block first,
		// which also gives the sender its pause until all results are in.
		// Phase 1 runs gapless while the receiver holds off, so the block
		// backs up; phase 3 is gapless too.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_cal(phase_cal[p][CAL_W-1:0]);
			if (p == 1) begin
				hold_off_req = 1'b1;
			end
			run_phase(PHASE_ITEMS, (p == 1 || p == 3));
		end

		in_valid <= 1'b0;
		wait_idle();
		if (mismatch_count == 0) begin
			$display("PASS ntc_adc_to_temperature_unit");
		end else begin
			$display("FAIL ntc_adc_to_temperature_unit");
		end
		$finish;
	end

endmodule

@@ ntc_adc_to_temperature_unit.f @@
sv/ntc_pkg.sv
sv/ntc_adc_to_temperature_unit.sv
sv/ntc_checker.sv
tb/sv/tb.sv
